// ===== sv/dq_pkg.sv =====
// Shared types and codes for the double-ended queue.
`default_nettype none

package dq_pkg;

  localparam int DQ_FIELD_W = 32;
  localparam int DQ_MAX_W   = 64;
  localparam int DQ_OCC_W   = 7;

  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_BACK   = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_PEEK       = 3'd4;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]            opcode;
    logic [DQ_FIELD_W-1:0] push_value;
  } dq_in_t;

  typedef struct packed {
    logic [DQ_FIELD_W-1:0] front_value;
    logic [DQ_FIELD_W-1:0] back_value;
    logic [DQ_OCC_W-1:0]   occupancy;
    logic [1:0]            status;
  } dq_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } dq_state_t;

  typedef struct packed {
    logic exec;
    logic rd;
    logic load;
  } dq_cmd_t;

endpackage

`default_nettype wire

// ===== sv/double_ended_queue.sv =====
// Top level of the bounded double-ended queue.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall   | dq_in_t  (opcode, push_value)
//   out_    | output    | out_valid / out_stall | dq_out_t (front, back, occupancy, status)
//
// Each transaction runs through execute (pointer update and store write),
// store read of the front and back slots, and result load; the single-port-write,
// dual-read ring store sets this sequence.
// A new transaction is taken while a finished result still waits on out_stall.
// The result load waits while the output register holds an untaken result.
// Reset (rst_n low, synchronous) empties the queue; store contents stay undefined.
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire dq_pkg::dq_in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output dq_pkg::dq_out_t      out_data
);

  dq_pkg::dq_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== sv/dq_ctrl.sv =====
// Control state machine: sequences execute, store read and result load.
`default_nettype none

module dq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           out_stall,
  output logic                out_valid,
  output dq_pkg::dq_cmd_t     cmd
);

  dq_pkg::dq_state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    unique case (state_r)
      dq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = dq_pkg::S_READ;
        end
      end
      dq_pkg::S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = dq_pkg::S_LOAD;
      end
      dq_pkg::S_LOAD: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = dq_pkg::S_IDLE;
        end
      end
      default: state_nxt = dq_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== sv/dq_datapath.sv =====
// Datapath: ring store, front/back positions, count and result register.
`default_nettype none

module dq_datapath #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire dq_pkg::dq_cmd_t cmd,
  input  wire dq_pkg::dq_in_t  in_data,
  output dq_pkg::dq_out_t      out_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ring_dec(input logic [PW-1:0] p);
    return (p == '0) ? LAST : p - 1'b1;
  endfunction

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [PW-1:0]         front_r, front_nxt;
  logic [PW-1:0]         back_r, back_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [DATA_WIDTH-1:0] front_q_r, back_q_r;
  dq_pkg::dq_out_t       out_r;

  logic                  wr_en;
  logic [PW-1:0]         wr_addr;
  logic [PW-1:0]         back_last;
  logic [dq_pkg::DQ_MAX_W-1:0] push_ext;
  logic [DATA_WIDTH-1:0] wdata;
  logic [dq_pkg::DQ_MAX_W-1:0] front_ext, back_ext;
  logic [31:0]           count_ext;
  logic                  full, empty;

  assign full      = (count_r == FULL);
  assign empty     = (count_r == '0);
  assign back_last = ring_dec(back_r);
  assign push_ext  = {{(dq_pkg::DQ_MAX_W - dq_pkg::DQ_FIELD_W){1'b0}}, in_data.push_value};
  assign wdata     = push_ext[DATA_WIDTH-1:0];
  assign front_ext = {{(dq_pkg::DQ_MAX_W - DATA_WIDTH){1'b0}}, front_q_r};
  assign back_ext  = {{(dq_pkg::DQ_MAX_W - DATA_WIDTH){1'b0}}, back_q_r};
  assign count_ext = 32'(count_r);

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_addr    = back_r;
    if (cmd.exec) begin
      status_nxt = dq_pkg::STAT_DONE;
      case (in_data.opcode)
        dq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status_nxt = dq_pkg::STAT_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = back_r;
            back_nxt  = ring_inc(back_r);
            count_nxt = count_r + 1'b1;
          end
        end
        dq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status_nxt = dq_pkg::STAT_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = ring_dec(front_r);
            front_nxt = ring_dec(front_r);
            count_nxt = count_r + 1'b1;
          end
        end
        dq_pkg::OP_POP_BACK: begin
          if (empty) begin
            status_nxt = dq_pkg::STAT_EMPTY;
          end else begin
            back_nxt  = back_last;
            count_nxt = count_r - 1'b1;
          end
        end
        dq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            status_nxt = dq_pkg::STAT_EMPTY;
          end else begin
            front_nxt = ring_inc(front_r);
            count_nxt = count_r - 1'b1;
          end
        end
        dq_pkg::OP_PEEK: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.rd) begin
      front_q_r <= mem[front_r];
      back_q_r  <= mem[back_last];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r.front_value <= empty ? '0 : front_ext[dq_pkg::DQ_FIELD_W-1:0];
      out_r.back_value  <= empty ? '0 : back_ext[dq_pkg::DQ_FIELD_W-1:0];
      out_r.occupancy   <= count_ext[dq_pkg::DQ_OCC_W-1:0];
      out_r.status      <= status_r;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== sv/dq_checker.sv =====
// Port-level assertions for the double-ended queue, bound to the top level.
`default_nettype none

module dq_checker #(
  parameter int DEPTH = 64
) (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_stall,
  input wire dq_pkg::dq_in_t  in_data,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire dq_pkg::dq_out_t out_data
);

  localparam logic [dq_pkg::DQ_OCC_W-1:0] FULL_OCC = dq_pkg::DQ_OCC_W'(DEPTH);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.occupancy == '0 |->
      out_data.front_value == '0 && out_data.back_value == '0)
    else $error("empty queue reports nonzero values");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == dq_pkg::STAT_FULL |-> out_data.occupancy == FULL_OCC)
    else $error("push dropped while not full");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == dq_pkg::STAT_EMPTY |-> out_data.occupancy == '0)
    else $error("pop ignored while not empty");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled transaction changed or withdrawn");

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);

`default_nettype wire

// ===== tb/double_ended_queue_tb.sv =====
// Self-checking testbench for the double-ended queue: directed table, fill pressure, random ops.
`timescale 1ns / 1ps

module double_ended_queue_tb;

  localparam int QDEPTH     = 64;
  localparam int QUIET_MAX  = 2000;
  localparam int HOLD_LEN   = 300;
  localparam int SEG_ITEMS  = 95;

  typedef struct {
    dq_pkg::dq_in_t  item;
    bit              fixed;
    dq_pkg::dq_out_t want;
  } dir_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  dq_pkg::dq_in_t  in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  dq_pkg::dq_out_t out_data;

  double_ended_queue uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  logic [31:0] ring [QDEPTH];
  logic [5:0]  head_pos = '0;
  logic [5:0]  tail_pos = '0;
  int unsigned fill_count = 0;

  dq_pkg::dq_out_t pending_results[$];
  dir_row_t        dir_rows[$];
  dq_pkg::dq_out_t oldest;

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int full_drops = 0;
  int empty_pops = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit pressure_on = 1'b0;
  bit pressure_done = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic dq_pkg::dq_out_t deque_op(dq_pkg::dq_in_t it);
    dq_pkg::dq_out_t r;
    r.status = dq_pkg::STAT_DONE;
    case (it.opcode)
      dq_pkg::OP_PUSH_BACK, dq_pkg::OP_PUSH_FRONT: begin
        if (fill_count >= QDEPTH) begin
          r.status = dq_pkg::STAT_FULL;
        end else if (it.opcode == dq_pkg::OP_PUSH_BACK) begin
          ring[tail_pos] = it.push_value;
          tail_pos = tail_pos + 6'd1;
          fill_count++;
        end else begin
          head_pos = head_pos - 6'd1;
          ring[head_pos] = it.push_value;
          fill_count++;
        end
      end
      dq_pkg::OP_POP_BACK, dq_pkg::OP_POP_FRONT: begin
        if (fill_count == 0) begin
          r.status = dq_pkg::STAT_EMPTY;
        end else if (it.opcode == dq_pkg::OP_POP_BACK) begin
          tail_pos = tail_pos - 6'd1;
          fill_count--;
        end else begin
          head_pos = head_pos + 6'd1;
          fill_count--;
        end
      end
      default: ;
    endcase
    if (fill_count == 0) begin
      r.front_value = '0;
      r.back_value  = '0;
    end else begin
      r.front_value = ring[head_pos];
      r.back_value  = ring[tail_pos - 6'd1];
    end
    r.occupancy = dq_pkg::DQ_OCC_W'(fill_count);
    return r;
  endfunction

  function automatic void add_row(logic [2:0] op, logic [31:0] val, bit fixed,
                                  logic [31:0] fv, logic [31:0] bv,
                                  logic [6:0] occ, logic [1:0] st);
    dir_row_t row;
    row.item.opcode      = op;
    row.item.push_value  = val;
    row.fixed            = fixed;
    row.want.front_value = fv;
    row.want.back_value  = bv;
    row.want.occupancy   = occ;
    row.want.status      = st;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic dq_pkg::dq_in_t pick_item(int push_pct);
    dq_pkg::dq_in_t it;
    if ($urandom_range(99) < 6) begin
      it.opcode = 3'($urandom_range(7, 4));
    end else if ($urandom_range(99) < push_pct) begin
      it.opcode = $urandom_range(1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK;
    end else begin
      it.opcode = $urandom_range(1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK;
    end
    case ($urandom_range(9))
      0:       it.push_value = '0;
      1:       it.push_value = '1;
      default: it.push_value = $urandom;
    endcase
    return it;
  endfunction

  task automatic send_item(dq_pkg::dq_in_t it, bit fixed, dq_pkg::dq_out_t want);
    dq_pkg::dq_out_t got;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = deque_op(it);
    pending_results.insert(pending_results.size(), fixed ? want : got);
    items_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: front %h back %h occupancy %0d status %0d",
               out_data.front_value, out_data.back_value,
               out_data.occupancy, out_data.status);
        errors++;
      end else begin
        oldest = pending_results[0];
        pending_results.delete(0);
        if (oldest.status == dq_pkg::STAT_FULL) full_drops++;
        if (oldest.status == dq_pkg::STAT_EMPTY) empty_pops++;
        if (out_data.front_value !== oldest.front_value) begin
          $error("front_value: expected %h, got %h", oldest.front_value,
                 out_data.front_value);
          errors++;
        end
        if (out_data.back_value !== oldest.back_value) begin
          $error("back_value: expected %h, got %h", oldest.back_value,
                 out_data.back_value);
          errors++;
        end
        if (out_data.occupancy !== oldest.occupancy) begin
          $error("occupancy: expected %0d, got %0d", oldest.occupancy,
                 out_data.occupancy);
          errors++;
        end
        if (out_data.status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, out_data.status);
          errors++;
        end
      end
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (pressure_on && !pressure_done) begin
      out_stall     <= 1'b1;
      hold_left     <= HOLD_LEN;
      pressure_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("timeout: no transaction for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  int idle_in_pct [4] = '{0, 67, 0, 34};
  int stall_out_pct [4] = '{0, 0, 67, 34};

  initial begin
    dq_pkg::dq_in_t  it;
    dq_pkg::dq_out_t none;
    none = '0;

    // empty queue, then a wrap of the front position below zero
    add_row(dq_pkg::OP_PEEK,       32'h0,        1, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_DONE);
    add_row(dq_pkg::OP_POP_BACK,   32'h0,        1, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_EMPTY);
    add_row(dq_pkg::OP_POP_FRONT,  32'hFFFFFFFF, 1, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_EMPTY);
    add_row(3'd5,                  32'hFFFFFFFF, 1, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_DONE);
    add_row(3'd7,                  32'h0,        1, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_DONE);
    add_row(dq_pkg::OP_PUSH_BACK,  32'hFFFFFFFF, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 7'd1,
            dq_pkg::STAT_DONE);
    add_row(dq_pkg::OP_PUSH_FRONT, 32'h0,        1, 32'h0, 32'hFFFFFFFF, 7'd2,
            dq_pkg::STAT_DONE);
    add_row(dq_pkg::OP_PUSH_BACK,  32'h00000001, 0, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_DONE);
    add_row(dq_pkg::OP_PUSH_FRONT, 32'h80000000, 0, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_DONE);
    add_row(dq_pkg::OP_PEEK,       32'hDEADBEEF, 0, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_DONE);
    add_row(3'd6,                  32'h12345678, 0, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_DONE);
    add_row(dq_pkg::OP_POP_BACK,   32'h0,        0, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_DONE);
    add_row(dq_pkg::OP_POP_FRONT,  32'h0,        0, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_DONE);
    add_row(dq_pkg::OP_POP_BACK,   32'h0,        0, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_DONE);
    add_row(dq_pkg::OP_POP_FRONT,  32'h0,        0, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_DONE);
    add_row(dq_pkg::OP_POP_FRONT,  32'h0,        1, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_EMPTY);
    add_row(dq_pkg::OP_PUSH_FRONT, 32'h12345678, 1, 32'h12345678, 32'h12345678, 7'd1,
            dq_pkg::STAT_DONE);
    add_row(dq_pkg::OP_POP_BACK,   32'h0,        1, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_DONE);
    add_row(dq_pkg::OP_PUSH_BACK,  32'h5A5A5A5A, 0, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_DONE);
    add_row(dq_pkg::OP_PUSH_FRONT, 32'hA5A5A5A5, 0, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_DONE);
    add_row(dq_pkg::OP_POP_FRONT,  32'h0,        0, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_DONE);
    add_row(dq_pkg::OP_POP_FRONT,  32'h0,        0, 32'h0, 32'h0, 7'd0,
            dq_pkg::STAT_DONE);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);

    // hold the output while pushes overrun the queue and back up the input
    pressure_on = 1'b1;
    for (int i = 0; i < 80; i++) begin
      it.opcode     = dq_pkg::OP_PUSH_BACK;
      it.push_value = $urandom;
      send_item(it, 0, none);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    pressure_on = 1'b0;

    for (int p = 0; p < 8; p++) begin
      idle_pct  = idle_in_pct[p % 4];
      stall_pct = stall_out_pct[p % 4];
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < SEG_ITEMS; i++) begin
          send_item(pick_item(((p + s) % 2 == 0) ? 85 : 15), 0, none);
        end
      end
    end
    in_valid <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d operations and %0d checked results", items_sent, results_seen);
    $display("including %0d pushes dropped when full and %0d pops on an empty queue",
             full_drops, empty_pops);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/dq_pkg.sv
sv/dq_ctrl.sv
sv/dq_datapath.sv
sv/double_ended_queue.sv
sv/dq_checker.sv
tb/double_ended_queue_tb.sv
